[rtl/nlcd_pkg.sv]
package nlcd_pkg;

   localparam int DISPLAY_CELLS = 10;
   localparam int CELL_W        = 8;
   localparam int VALUE_W       = 32;
   localparam int CMD_W         = 3;
   localparam int NIBBLE_W      = 4;
   localparam int HEX_DIGITS    = 8;
   localparam int BCD_W         = 4 * DISPLAY_CELLS;
   localparam int CONV_STEPS    = VALUE_W;
   localparam int ITER_W        = $clog2(CONV_STEPS);
   localparam int BEAT_W        = 5;
   localparam int CELL_IDX_W    = $clog2(DISPLAY_CELLS);

   localparam logic [BEAT_W-1:0] BEAT_FINAL     = BEAT_W'(2 * DISPLAY_CELLS);
   localparam logic [BEAT_W-1:0] PREAMBLE_BEATS = BEAT_W'(2);

   localparam logic [NIBBLE_W-1:0] NIB_UNLOCK_ADDR = 4'hF;
   localparam logic [NIBBLE_W-1:0] NIB_UNLOCK_DATA = 4'h1;
   localparam logic [NIBBLE_W-1:0] NIB_CODE_ADDR   = 4'h0;

   localparam logic [CELL_W-1:0] CODE_BLANK    = 8'h00;
   localparam logic [CELL_W-1:0] CODE_MINUS    = 8'h01;
   localparam logic [CELL_W-1:0] CODE_LETTER_B = 8'hC7;
   localparam logic [CELL_W-1:0] CODE_LETTER_H = 8'hC3;

   localparam logic [VALUE_W-1:0] SIGN_BIT      = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] MAG_MASK      = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] DEC_CLAMP     = 32'd999999999;
   localparam logic [VALUE_W-1:0] DEC_NEG_LIMIT = SIGN_BIT + DEC_CLAMP;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT   = 3'd0,
      CMD_RAW    = 3'd1,
      CMD_STRING = 3'd2,
      CMD_BINARY = 3'd3,
      CMD_UDEC   = 3'd4,
      CMD_SDEC   = 3'd5,
      CMD_UHEX   = 3'd6,
      CMD_SHEX   = 3'd7
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_BUILD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic build;
      logic emit;
   } nlcd_cmd_type;

   typedef struct packed {
      logic is_dec;
      logic iter_done;
      logic beat_final;
      logic out_free;
   } nlcd_status_type;

   function automatic logic [CELL_W-1:0] char_to_code(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] code;
      case (c)
         "0":     code = 8'hEE;
         "1":     code = 8'h60;
         "2":     code = 8'h2F;
         "3":     code = 8'h6D;
         "4":     code = 8'hE1;
         "5":     code = 8'hCD;
         "6":     code = 8'hCF;
         "7":     code = 8'h68;
         "8":     code = 8'hEF;
         "9":     code = 8'hED;
         "A":     code = 8'hEB;
         "b":     code = 8'hC7;
         "c":     code = 8'h07;
         "d":     code = 8'h67;
         "E":     code = 8'h8F;
         "F":     code = 8'h8B;
         "-":     code = 8'h01;
         "*":     code = 8'hA9;
         "J":     code = 8'h6E;
         "G":     code = 8'hCE;
         "h":     code = 8'hC3;
         "L":     code = 8'h86;
         "n":     code = 8'h43;
         "o":     code = 8'h47;
         "P":     code = 8'hAB;
         "r":     code = 8'h03;
         "U":     code = 8'hE6;
         "X":     code = 8'hE3;
         "Y":     code = 8'hE5;
         "=":     code = 8'h05;
         "_":     code = 8'h04;
         "!":     code = 8'h70;
         "^":     code = 8'h41;
         default: code = CODE_BLANK;
      endcase
      return code;
   endfunction

   function automatic logic [CELL_W-1:0] digit_code(input logic [3:0] d);
      logic [CELL_W-1:0] code;
      case (d)
         4'h0:    code = 8'hEE;
         4'h1:    code = 8'h60;
         4'h2:    code = 8'h2F;
         4'h3:    code = 8'h6D;
         4'h4:    code = 8'hE1;
         4'h5:    code = 8'hCD;
         4'h6:    code = 8'hCF;
         4'h7:    code = 8'h68;
         4'h8:    code = 8'hEF;
         4'h9:    code = 8'hED;
         4'hA:    code = 8'hEB;
         4'hB:    code = 8'hC7;
         4'hC:    code = 8'h07;
         4'hD:    code = 8'h67;
         4'hE:    code = 8'h8F;
         4'hF:    code = 8'h8B;
         default: code = CODE_BLANK;
      endcase
      return code;
   endfunction

endpackage

[rtl/nlcd_ctrl.sv]
module nlcd_ctrl
   import nlcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  nlcd_status_type status,
   output nlcd_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (!status.is_dec || status.iter_done) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free && status.beat_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.step = status.is_dec;
         end
         ST_BUILD: begin
            cmd.build = 1'b1;
         end
         ST_SEND: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[rtl/nlcd_datapath.sv]
module nlcd_datapath
   import nlcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  nlcd_cmd_type        cmd,
   output nlcd_status_type     status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [CELL_W-1:0]   req_cells [DISPLAY_CELLS],
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_addr_select,
   output logic [NIBBLE_W-1:0] rsp_nibble,
   output logic                rsp_release_enable,
   output logic                rsp_last
);

   cmd_code_type      cmd_ff;
   cmd_code_type      cmd_in;
   logic              neg_ff;
   logic              neg_in;
   logic [VALUE_W-1:0] bin_ff;
   logic [VALUE_W-1:0] bin_in;
   logic [BCD_W-1:0]  bcd_ff;
   logic [BCD_W-1:0]  bcd_in;
   logic [ITER_W-1:0] iter_ff;
   logic [ITER_W-1:0] iter_in;
   logic [BEAT_W-1:0] beat_ff;
   logic [BEAT_W-1:0] beat_in;
   logic [CELL_W-1:0] cells_ff [DISPLAY_CELLS];
   logic [CELL_W-1:0] codes_ff [DISPLAY_CELLS];
   logic [CELL_W-1:0] codes_in [DISPLAY_CELLS];

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                addr_sel_ff;
   logic                addr_sel_in;
   logic [NIBBLE_W-1:0] nibble_ff;
   logic [NIBBLE_W-1:0] nibble_in;
   logic                rel_ff;
   logic                rel_in;
   logic                last_ff;
   logic                last_in;

   logic                req_signed;
   logic                req_neg;
   logic [BCD_W-1:0]    bcd_adj;
   logic [DISPLAY_CELLS-1:0] dkeep;
   logic [DISPLAY_CELLS-1:0] dsign;
   logic [HEX_DIGITS-1:0]    hkeep;
   logic [HEX_DIGITS-1:0]    hsign;
   logic [CELL_W-1:0]   sign_code;
   logic                init_mode;
   logic                preamble;
   logic [BEAT_W-1:0]   code_beat;
   logic [BEAT_W-1:0]   data_beat;
   logic [CELL_IDX_W-1:0] cell_idx;
   logic [CELL_W-1:0]   cell_code;
   logic                out_free;

   assign req_signed = (cmd_code_type'(req_cmd) == CMD_SDEC) ||
                       (cmd_code_type'(req_cmd) == CMD_SHEX);
   assign req_neg    = req_signed && (req_value > SIGN_BIT);

   always_comb begin
      cmd_in = cmd_ff;
      neg_in = neg_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      iter_in = iter_ff;
      if (cmd.load) begin
         cmd_in  = cmd_code_type'(req_cmd);
         neg_in  = req_neg;
         bcd_in  = '0;
         iter_in = '0;
         if (!req_neg) begin
            bin_in = req_value;
         end else if ((cmd_code_type'(req_cmd) == CMD_SDEC) && (req_value > DEC_NEG_LIMIT)) begin
            bin_in = DEC_CLAMP;
         end else begin
            bin_in = req_value & MAG_MASK;
         end
      end else if (cmd.step) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         iter_in = iter_ff + ITER_W'(1);
      end
   end

   always_comb begin
      for (int d = 0; d < DISPLAY_CELLS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      logic dacc;
      logic hacc;
      dacc = 1'b0;
      hacc = 1'b0;
      for (int i = DISPLAY_CELLS - 1; i >= 0; i--) begin
         dacc     = dacc | (|bcd_ff[4*i +: 4]);
         dkeep[i] = dacc || (i == 0);
      end
      for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
         hacc     = hacc | (|bin_ff[4*i +: 4]);
         hkeep[i] = hacc || (i == 0);
      end
      dsign[0] = 1'b0;
      for (int i = 1; i < DISPLAY_CELLS; i++) begin
         dsign[i] = dkeep[i-1] && !dkeep[i];
      end
      hsign[0] = 1'b0;
      for (int i = 1; i < HEX_DIGITS; i++) begin
         hsign[i] = hkeep[i-1] && !hkeep[i];
      end
   end

   assign sign_code = neg_ff ? CODE_MINUS : CODE_BLANK;

   always_comb begin
      for (int i = 0; i < DISPLAY_CELLS; i++) begin
         codes_in[i] = CODE_BLANK;
      end
      case (cmd_ff)
         CMD_INIT: begin
            for (int i = 0; i < DISPLAY_CELLS; i++) begin
               codes_in[i] = CODE_BLANK;
            end
         end
         CMD_RAW: begin
            for (int i = 0; i < DISPLAY_CELLS; i++) begin
               codes_in[i] = cells_ff[i];
            end
         end
         CMD_STRING: begin
            for (int i = 0; i < DISPLAY_CELLS; i++) begin
               codes_in[i] = char_to_code(cells_ff[i]);
            end
         end
         CMD_BINARY: begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
               codes_in[i] = digit_code({3'b000, bin_ff[i]});
            end
            codes_in[DISPLAY_CELLS-2] = CODE_BLANK;
            codes_in[DISPLAY_CELLS-1] = CODE_LETTER_B;
         end
         CMD_UDEC, CMD_SDEC: begin
            for (int i = 0; i < DISPLAY_CELLS; i++) begin
               if (dkeep[i]) begin
                  codes_in[i] = digit_code(bcd_ff[4*i +: 4]);
               end else if (dsign[i]) begin
                  codes_in[i] = sign_code;
               end else begin
                  codes_in[i] = CODE_BLANK;
               end
            end
         end
         CMD_UHEX, CMD_SHEX: begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
               if (hkeep[i]) begin
                  codes_in[i] = digit_code(bin_ff[4*i +: 4]);
               end else if (hsign[i]) begin
                  codes_in[i] = sign_code;
               end else begin
                  codes_in[i] = CODE_BLANK;
               end
            end
            codes_in[DISPLAY_CELLS-2] = hkeep[HEX_DIGITS-1] ? sign_code : CODE_BLANK;
            codes_in[DISPLAY_CELLS-1] = CODE_LETTER_H;
         end
         default: begin
            codes_in[0] = CODE_BLANK;
         end
      endcase
   end

   // Init runs two unlock beats ahead of the normal address and data beats.
   assign init_mode = (cmd_ff == CMD_INIT);
   assign preamble  = init_mode && (beat_ff < PREAMBLE_BEATS);
   assign code_beat = init_mode ? (beat_ff - PREAMBLE_BEATS) : beat_ff;
   assign data_beat = code_beat - BEAT_W'(1);
   assign cell_idx  = CELL_IDX_W'(DISPLAY_CELLS - 1) - CELL_IDX_W'(data_beat[BEAT_W-1:1]);

   always_comb begin
      cell_code = CODE_BLANK;
      for (int i = 0; i < DISPLAY_CELLS; i++) begin
         if (cell_idx == CELL_IDX_W'(i)) begin
            cell_code = codes_ff[i];
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      addr_sel_in  = addr_sel_ff;
      nibble_in    = nibble_ff;
      rel_in       = rel_ff;
      last_in      = last_ff;
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.build) begin
         beat_in = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         beat_in      = beat_ff + BEAT_W'(1);
         if (preamble) begin
            addr_sel_in = beat_ff[0];
            nibble_in   = beat_ff[0] ? NIB_UNLOCK_DATA : NIB_UNLOCK_ADDR;
            rel_in      = beat_ff[0];
            last_in     = 1'b0;
         end else if (code_beat == '0) begin
            addr_sel_in = 1'b0;
            nibble_in   = NIB_CODE_ADDR;
            rel_in      = 1'b0;
            last_in     = 1'b0;
         end else begin
            addr_sel_in = 1'b1;
            nibble_in   = data_beat[0] ? cell_code[CELL_W-1:NIBBLE_W] : cell_code[NIBBLE_W-1:0];
            rel_in      = (code_beat == BEAT_FINAL);
            last_in     = (code_beat == BEAT_FINAL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      neg_ff      <= neg_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      iter_ff     <= iter_in;
      beat_ff     <= beat_in;
      addr_sel_ff <= addr_sel_in;
      nibble_ff   <= nibble_in;
      rel_ff      <= rel_in;
      last_ff     <= last_in;
      for (int i = 0; i < DISPLAY_CELLS; i++) begin
         if (cmd.load) begin
            cells_ff[i] <= req_cells[i];
         end
         if (cmd.build) begin
            codes_ff[i] <= codes_in[i];
         end
      end
   end

   assign status.is_dec     = (cmd_ff == CMD_UDEC) || (cmd_ff == CMD_SDEC);
   assign status.iter_done  = (iter_ff == ITER_W'(CONV_STEPS - 1));
   assign status.beat_final = !preamble && (code_beat == BEAT_FINAL);
   assign status.out_free   = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_addr_select    = addr_sel_ff;
   assign rsp_nibble         = nibble_ff;
   assign rsp_release_enable = rel_ff;
   assign rsp_last           = last_ff;

endmodule

[rtl/number_to_segment_lcd_writer.sv]
// Channel   Ports                      Beat contents
// req       req_valid / req_ready      cmd, value, cell0 .. cell9
// rsp       rsp_valid / rsp_ready      addr_select, nibble, release_enable, last
//
// A decimal command is accepted, converted from binary to BCD one shift per value bit,
// built and then sent as 21 bus beats; other commands skip the conversion, and init
// sends two unlock beats first. A beat that rsp_ready holds back stalls the sequence.
// A new command is taken once the last beat of the previous one sits in the output
// register. Reset is synchronous and returns the block to idle with no beat pending.
module number_to_segment_lcd_writer
   import nlcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [CELL_W-1:0]   req_cell0,
   input  logic [CELL_W-1:0]   req_cell1,
   input  logic [CELL_W-1:0]   req_cell2,
   input  logic [CELL_W-1:0]   req_cell3,
   input  logic [CELL_W-1:0]   req_cell4,
   input  logic [CELL_W-1:0]   req_cell5,
   input  logic [CELL_W-1:0]   req_cell6,
   input  logic [CELL_W-1:0]   req_cell7,
   input  logic [CELL_W-1:0]   req_cell8,
   input  logic [CELL_W-1:0]   req_cell9,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_addr_select,
   output logic [NIBBLE_W-1:0] rsp_nibble,
   output logic                rsp_release_enable,
   output logic                rsp_last
);

   nlcd_cmd_type    cmd;
   nlcd_status_type status;
   logic [CELL_W-1:0] req_cells [DISPLAY_CELLS];

   assign req_cells[0] = req_cell0;
   assign req_cells[1] = req_cell1;
   assign req_cells[2] = req_cell2;
   assign req_cells[3] = req_cell3;
   assign req_cells[4] = req_cell4;
   assign req_cells[5] = req_cell5;
   assign req_cells[6] = req_cell6;
   assign req_cells[7] = req_cell7;
   assign req_cells[8] = req_cell8;
   assign req_cells[9] = req_cell9;

   nlcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nlcd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_value          (req_value),
      .req_cells          (req_cells),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_addr_select    (rsp_addr_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_release_enable (rsp_release_enable),
      .rsp_last           (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_last_releases : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_release_enable && rsp_addr_select)
      else $error("Final beat does not release the chip enable.");

   a_unlock_release : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_enable && !rsp_last |->
         rsp_addr_select && (rsp_nibble == NIB_UNLOCK_DATA))
      else $error("Early release on a beat other than the unlock data.");

   a_addr_nibble : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_addr_select |->
         (rsp_nibble == NIB_CODE_ADDR) || (rsp_nibble == NIB_UNLOCK_ADDR))
      else $error("Address beat carries an unexpected nibble.");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Command accepted while the previous one is still in progress.");
`endif

endmodule
